[hdl/lvg_pkg.sv]
`default_nettype none

package lvg_pkg;

    localparam int STREAK_WIDTH_DEF = 8;
    localparam int FRAC_BITS_DEF    = 8;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 8;
    localparam int LEVEL_W  = 3;
    localparam int CLASS_W  = 2;
    localparam int INDEX_W  = 3;
    localparam int COEF_W   = 14;
    localparam int FRAC_W   = 9;

    localparam logic [LEVEL_W-1:0]  LEVEL_TOP = 3'd4;
    localparam logic [SAMPLE_W-1:0] HALF_MS   = 16'd128;
    localparam logic [COEF_W-1:0]   FALL_COEF = 14'd13107;
    localparam logic [COEF_W-1:0]   RISE_COEF = 14'd328;

    localparam logic [SAMPLE_W-1:0] HEAVY_RESET  = 16'd2048;
    localparam logic [SAMPLE_W-1:0] QUIET_RESET  = 16'd1024;
    localparam logic [COUNT_W-1:0]  RAISE_RESET  = 8'd3;
    localparam logic [COUNT_W-1:0]  LOWER_RESET  = 8'd30;
    localparam logic [SAMPLE_W-1:0] BUDGET_RESET = 16'd1024;

    typedef enum logic [INDEX_W-1:0] {
        REG_HEAVY_THRESHOLD = 3'd0,
        REG_QUIET_THRESHOLD = 3'd1,
        REG_FRAMES_TO_RAISE = 3'd2,
        REG_FRAMES_TO_LOWER = 3'd3,
        REG_BASE_BUDGET     = 3'd4
    } reg_index_t;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_BETWEEN = 2'd0,
        CLASS_HEAVY   = 2'd1,
        CLASS_QUIET   = 2'd2
    } frame_class_t;

    typedef struct packed {
        logic heavy;
        logic quiet;
    } frame_flags_t;

    function automatic logic [FRAC_W-1:0] level_frac(input logic [LEVEL_W-1:0] level);
        logic [FRAC_W-1:0] frac;
        case (level)
            3'd0:    frac = 9'd256;
            3'd1:    frac = 9'd205;
            3'd2:    frac = 9'd154;
            3'd3:    frac = 9'd115;
            default: frac = 9'd77;
        endcase
        return frac;
    endfunction

endpackage

`default_nettype wire

[hdl/load_level_governor.sv]
`default_nettype none

// Channel     Direction  Payload
// s_*         in         sample_ms [15:0]
// m_*         out        shed_level, peak_level, baseline_out, budget_out, frame_class
// cfg_*       in         register index [2:0], write data [15:0]
//
// One sample a cycle unless the output stalls; sample and result are registered.
// The sample register feeds one pass of compare, baseline multiply and level update.
// Reset loads register defaults and sets the baseline to the effective quiet threshold.
// A stalled result holds in the output register; the sample register fills if empty.

module load_level_governor #(
    parameter int STREAK_WIDTH = lvg_pkg::STREAK_WIDTH_DEF,
    parameter int FRAC_BITS    = lvg_pkg::FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // sample_ms [15:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // shed_level [2:0], peak_level [5:3],
                                        // baseline_out [21:6], budget_out [37:22],
                                        // frame_class [39:38]
    input  wire logic        cfg_wen,
    input  wire logic [lvg_pkg::INDEX_W-1:0] cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    logic [lvg_pkg::SAMPLE_W-1:0] heavy_thr_reg;
    logic [lvg_pkg::SAMPLE_W-1:0] quiet_thr_reg;
    logic [lvg_pkg::COUNT_W-1:0]  raise_reg;
    logic [lvg_pkg::COUNT_W-1:0]  lower_reg;
    logic [lvg_pkg::SAMPLE_W-1:0] budget_reg;
    logic [lvg_pkg::SAMPLE_W-1:0] quiet_eff;
    logic                         reload;
    logic [lvg_pkg::SAMPLE_W-1:0] heavy_new;
    logic [lvg_pkg::SAMPLE_W-1:0] quiet_new;
    logic [lvg_pkg::SAMPLE_W-1:0] reload_qe;

    logic                         in_valid_reg;
    logic [lvg_pkg::SAMPLE_W-1:0] sample_reg;
    logic                         out_valid_reg;
    logic [39:0]                  out_data_reg;
    logic                         advance;

    lvg_pkg::frame_flags_t        flags;
    logic [lvg_pkg::SAMPLE_W-1:0] baseline_val;
    logic [lvg_pkg::LEVEL_W-1:0]  level_val;
    logic [lvg_pkg::LEVEL_W-1:0]  peak_val;
    logic [lvg_pkg::SAMPLE_W-1:0] budget_val;
    lvg_pkg::frame_class_t        class_val;

    assign quiet_eff = (quiet_thr_reg < heavy_thr_reg) ? quiet_thr_reg : heavy_thr_reg;
    assign reload    = cfg_wen && ((cfg_addr == lvg_pkg::REG_HEAVY_THRESHOLD) ||
                                   (cfg_addr == lvg_pkg::REG_QUIET_THRESHOLD));

    // reload from the threshold values that this write leaves behind
    assign heavy_new = (cfg_addr == lvg_pkg::REG_HEAVY_THRESHOLD) ? cfg_wdata : heavy_thr_reg;
    assign quiet_new = (cfg_addr == lvg_pkg::REG_QUIET_THRESHOLD) ? cfg_wdata : quiet_thr_reg;
    assign reload_qe = (quiet_new < heavy_new) ? quiet_new : heavy_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heavy_thr_reg <= lvg_pkg::HEAVY_RESET;
            quiet_thr_reg <= lvg_pkg::QUIET_RESET;
            raise_reg     <= lvg_pkg::RAISE_RESET;
            lower_reg     <= lvg_pkg::LOWER_RESET;
            budget_reg    <= lvg_pkg::BUDGET_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                lvg_pkg::REG_HEAVY_THRESHOLD: heavy_thr_reg <= cfg_wdata;
                lvg_pkg::REG_QUIET_THRESHOLD: quiet_thr_reg <= cfg_wdata;
                lvg_pkg::REG_FRAMES_TO_RAISE: raise_reg     <= cfg_wdata[7:0];
                lvg_pkg::REG_FRAMES_TO_LOWER: lower_reg     <= cfg_wdata[7:0];
                lvg_pkg::REG_BASE_BUDGET:     budget_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            sample_reg <= s_tdata;
        end
        if (advance)
        begin
            out_data_reg <= {class_val, budget_val, baseline_val, peak_val, level_val};
        end
    end

    lvg_baseline #(
        .FRAC_BITS(FRAC_BITS)
    ) u_baseline (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .reload       (reload),
        .reload_level (reload_qe),
        .sample       (sample_reg),
        .heavy_thr    (heavy_thr_reg),
        .quiet_eff    (quiet_eff),
        .flags        (flags),
        .baseline_out (baseline_val)
    );

    lvg_level #(
        .STREAK_WIDTH(STREAK_WIDTH)
    ) u_level (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .flags           (flags),
        .frames_to_raise (raise_reg),
        .frames_to_lower (lower_reg),
        .base_budget     (budget_reg),
        .level_out       (level_val),
        .peak_out        (peak_val),
        .budget_out      (budget_val),
        .class_out       (class_val)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

[hdl/lvg_baseline.sv]
`default_nettype none

module lvg_baseline #(
    parameter int FRAC_BITS = lvg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic                          reload,
    input  wire logic [lvg_pkg::SAMPLE_W-1:0]  reload_level,
    input  wire logic [lvg_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic [lvg_pkg::SAMPLE_W-1:0]  heavy_thr,
    input  wire logic [lvg_pkg::SAMPLE_W-1:0]  quiet_eff,
    output lvg_pkg::frame_flags_t              flags,
    output logic      [lvg_pkg::SAMPLE_W-1:0]  baseline_out
);

    localparam int BW   = lvg_pkg::SAMPLE_W + FRAC_BITS;
    localparam int PW   = BW + lvg_pkg::COEF_W;

    logic [BW-1:0] baseline_reg;
    logic [BW-1:0] baseline_next;
    logic [BW-1:0] big;
    logic [BW-1:0] reload_val;
    logic [lvg_pkg::SAMPLE_W-1:0] margin;
    logic [lvg_pkg::SAMPLE_W-1:0] margin_raw;
    logic [BW:0]   heavy_lim;
    logic [BW:0]   quiet_lim;
    logic          falling;
    logic [BW-1:0] diff;
    logic [lvg_pkg::COEF_W-1:0] coef;
    logic [PW-1:0] prod;
    logic [BW-1:0] delta;

    assign big        = {sample, {FRAC_BITS{1'b0}}};
    assign reload_val = {reload_level, {FRAC_BITS{1'b0}}};
    assign margin_raw = heavy_thr - quiet_eff;
    assign margin     = (margin_raw < lvg_pkg::HALF_MS) ? lvg_pkg::HALF_MS : margin_raw;
    assign heavy_lim  = {1'b0, baseline_reg} + {1'b0, margin, {FRAC_BITS{1'b0}}};
    assign quiet_lim  = {1'b0, baseline_reg} + {2'b00, margin, {(FRAC_BITS-1){1'b0}}};

    assign flags.heavy = (sample > heavy_thr) && ({1'b0, big} > heavy_lim);
    assign flags.quiet = (sample < quiet_eff) || ({1'b0, big} < quiet_lim);

    assign falling = big < baseline_reg;
    assign diff    = falling ? (baseline_reg - big) : (big - baseline_reg);
    assign coef    = falling ? lvg_pkg::FALL_COEF : lvg_pkg::RISE_COEF;
    assign prod    = PW'(diff) * PW'(coef);
    assign delta   = BW'(prod[PW-1:16]);

    always_comb
    begin
        if (falling)
        begin
            baseline_next = baseline_reg - delta;
        end
        else
        begin
            baseline_next = baseline_reg + delta;
        end
    end

    assign baseline_out = baseline_next[BW-1:FRAC_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg <= {lvg_pkg::QUIET_RESET, {FRAC_BITS{1'b0}}};
        end
        else if (reload)
        begin
            baseline_reg <= reload_val;
        end
        else if (advance)
        begin
            baseline_reg <= baseline_next;
        end
    end

endmodule

`default_nettype wire

[hdl/lvg_level.sv]
`default_nettype none

module lvg_level #(
    parameter int STREAK_WIDTH = lvg_pkg::STREAK_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire lvg_pkg::frame_flags_t         flags,
    input  wire logic [lvg_pkg::COUNT_W-1:0]   frames_to_raise,
    input  wire logic [lvg_pkg::COUNT_W-1:0]   frames_to_lower,
    input  wire logic [lvg_pkg::SAMPLE_W-1:0]  base_budget,
    output logic      [lvg_pkg::LEVEL_W-1:0]   level_out,
    output logic      [lvg_pkg::LEVEL_W-1:0]   peak_out,
    output logic      [lvg_pkg::SAMPLE_W-1:0]  budget_out,
    output lvg_pkg::frame_class_t              class_out
);

    localparam int SW = STREAK_WIDTH;
    localparam int CW = (SW > lvg_pkg::COUNT_W) ? SW : lvg_pkg::COUNT_W;
    localparam int BPW = lvg_pkg::SAMPLE_W + lvg_pkg::FRAC_W;
    localparam logic [SW-1:0] STREAK_MAX = {SW{1'b1}};

    logic [SW-1:0] heavy_streak_reg, heavy_streak_next;
    logic [SW-1:0] quiet_streak_reg, quiet_streak_next;
    logic [lvg_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic [lvg_pkg::LEVEL_W-1:0] peak_reg, peak_next;
    logic [SW-1:0] heavy_inc;
    logic [SW-1:0] quiet_inc;
    logic [lvg_pkg::COUNT_W-1:0] raise_thr;
    logic [lvg_pkg::COUNT_W-1:0] lower_thr;
    logic [BPW-1:0] budget_prod;

    assign heavy_inc = (heavy_streak_reg < STREAK_MAX) ? heavy_streak_reg + 1'b1
                                                       : heavy_streak_reg;
    assign quiet_inc = (quiet_streak_reg < STREAK_MAX) ? quiet_streak_reg + 1'b1
                                                       : quiet_streak_reg;
    assign raise_thr = (frames_to_raise == '0) ? lvg_pkg::COUNT_W'(1) : frames_to_raise;
    assign lower_thr = (frames_to_lower == '0) ? lvg_pkg::COUNT_W'(1) : frames_to_lower;

    always_comb
    begin
        heavy_streak_next = heavy_streak_reg;
        quiet_streak_next = quiet_streak_reg;
        level_next        = level_reg;
        peak_next         = peak_reg;
        class_out         = lvg_pkg::CLASS_BETWEEN;
        if (flags.heavy)
        begin
            class_out         = lvg_pkg::CLASS_HEAVY;
            heavy_streak_next = heavy_inc;
            if (CW'(heavy_inc) >= CW'(raise_thr))
            begin
                heavy_streak_next = '0;
                quiet_streak_next = '0;
                if (level_reg < lvg_pkg::LEVEL_TOP)
                begin
                    level_next = level_reg + 1'b1;
                end
                if (level_next > peak_reg)
                begin
                    peak_next = level_next;
                end
            end
        end
        else if (flags.quiet)
        begin
            class_out         = lvg_pkg::CLASS_QUIET;
            heavy_streak_next = '0;
            quiet_streak_next = quiet_inc;
            if (CW'(quiet_inc) >= CW'(lower_thr))
            begin
                quiet_streak_next = '0;
                if (level_reg != '0)
                begin
                    level_next = level_reg - 1'b1;
                end
            end
        end
        else
        begin
            heavy_streak_next = '0;
        end
    end

    assign budget_prod = BPW'(base_budget) * BPW'(lvg_pkg::level_frac(level_next));
    assign budget_out  = budget_prod[lvg_pkg::SAMPLE_W+7:8];
    assign level_out   = level_next;
    assign peak_out    = peak_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heavy_streak_reg <= '0;
            quiet_streak_reg <= '0;
            level_reg        <= '0;
            peak_reg         <= '0;
        end
        else if (advance)
        begin
            heavy_streak_reg <= heavy_streak_next;
            quiet_streak_reg <= quiet_streak_next;
            level_reg        <= level_next;
            peak_reg         <= peak_next;
        end
    end

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int FRAC       = lvg_pkg::FRAC_BITS_DEF;
    localparam int STREAK_TOP = (1 << lvg_pkg::STREAK_WIDTH_DEF) - 1;

    localparam logic [lvg_pkg::INDEX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [lvg_pkg::INDEX_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef struct {
        bit [lvg_pkg::LEVEL_W-1:0]  shed;
        bit [lvg_pkg::LEVEL_W-1:0]  peak;
        bit [lvg_pkg::SAMPLE_W-1:0] baseline_q;
        bit [lvg_pkg::SAMPLE_W-1:0] budget;
        lvg_pkg::frame_class_t      cls;
    } level_report_t;

    class level_tracker;
        bit [lvg_pkg::SAMPLE_W-1:0] heavy_thr;
        bit [lvg_pkg::SAMPLE_W-1:0] quiet_thr;
        bit [lvg_pkg::COUNT_W-1:0]  raise_count;
        bit [lvg_pkg::COUNT_W-1:0]  lower_count;
        bit [lvg_pkg::SAMPLE_W-1:0] budget_full;
        bit [31:0]                  baseline;
        bit [lvg_pkg::COUNT_W-1:0]  heavy_streak;
        bit [lvg_pkg::COUNT_W-1:0]  quiet_streak;
        bit [lvg_pkg::LEVEL_W-1:0]  level;
        bit [lvg_pkg::LEVEL_W-1:0]  peak;
        level_report_t              due_outputs[$];
        int                         mismatches;

        function new();
            heavy_thr    = lvg_pkg::HEAVY_RESET;
            quiet_thr    = lvg_pkg::QUIET_RESET;
            raise_count  = lvg_pkg::RAISE_RESET;
            lower_count  = lvg_pkg::LOWER_RESET;
            budget_full  = lvg_pkg::BUDGET_RESET;
            heavy_streak = '0;
            quiet_streak = '0;
            level        = '0;
            peak         = '0;
            mismatches   = 0;
            reload_baseline();
        endfunction

        function bit [lvg_pkg::SAMPLE_W-1:0] quiet_level();
            return (quiet_thr < heavy_thr) ? quiet_thr : heavy_thr;
        endfunction

        function bit [lvg_pkg::SAMPLE_W-1:0] margin_now();
            bit [lvg_pkg::SAMPLE_W-1:0] m;
            m = heavy_thr - quiet_level();
            return (m < lvg_pkg::HALF_MS) ? lvg_pkg::HALF_MS : m;
        endfunction

        function void reload_baseline();
            baseline = 32'(quiet_level()) << FRAC;
        endfunction

        function int raise_eff();
            return (raise_count == 0) ? 1 : int'(raise_count);
        endfunction

        function int lower_eff();
            return (lower_count == 0) ? 1 : int'(lower_count);
        endfunction

        function bit [8:0] level_share(bit [lvg_pkg::LEVEL_W-1:0] lvl);
            case (lvl)
                3'd0:    return 9'd256;
                3'd1:    return 9'd205;
                3'd2:    return 9'd154;
                3'd3:    return 9'd115;
                default: return 9'd77;
            endcase
        endfunction

        function void write_reg(logic [lvg_pkg::INDEX_W-1:0] index, logic [15:0] value);
            case (index)
                lvg_pkg::REG_HEAVY_THRESHOLD:
                begin
                    heavy_thr = value;
                    reload_baseline();
                end
                lvg_pkg::REG_QUIET_THRESHOLD:
                begin
                    quiet_thr = value;
                    reload_baseline();
                end
                lvg_pkg::REG_FRAMES_TO_RAISE: raise_count = value[lvg_pkg::COUNT_W-1:0];
                lvg_pkg::REG_FRAMES_TO_LOWER: lower_count = value[lvg_pkg::COUNT_W-1:0];
                lvg_pkg::REG_BASE_BUDGET:     budget_full = value;
                default: ;
            endcase
        endfunction

        function void take_sample(logic [lvg_pkg::SAMPLE_W-1:0] s);
            bit [31:0]                  big;
            bit [47:0]                  prod;
            bit [lvg_pkg::SAMPLE_W-1:0] qe;
            bit [lvg_pkg::SAMPLE_W-1:0] m;
            bit                         hv;
            bit                         qt;
            level_report_t              r;
            qe  = quiet_level();
            m   = margin_now();
            big = 32'(s) << FRAC;
            hv  = (s > heavy_thr) && (big > baseline + (32'(m) << FRAC));
            qt  = (s < qe) || (big < baseline + (32'(m) << (FRAC - 1)));
            if (big < baseline)
            begin
                prod = 48'(baseline - big) * 48'(lvg_pkg::FALL_COEF);
                baseline = baseline - 32'(prod >> 16);
            end
            else
            begin
                prod = 48'(big - baseline) * 48'(lvg_pkg::RISE_COEF);
                baseline = baseline + 32'(prod >> 16);
            end
            if (hv)
            begin
                r.cls = lvg_pkg::CLASS_HEAVY;
                if (heavy_streak < STREAK_TOP)
                    heavy_streak++;
                if (heavy_streak >= raise_eff())
                begin
                    heavy_streak = '0;
                    quiet_streak = '0;
                    if (level < lvg_pkg::LEVEL_TOP)
                        level++;
                    if (level > peak)
                        peak = level;
                end
            end
            else if (qt)
            begin
                r.cls = lvg_pkg::CLASS_QUIET;
                heavy_streak = '0;
                if (quiet_streak < STREAK_TOP)
                    quiet_streak++;
                if (quiet_streak >= lower_eff())
                begin
                    quiet_streak = '0;
                    if (level > 0)
                        level--;
                end
            end
            else
            begin
                r.cls = lvg_pkg::CLASS_BETWEEN;
                heavy_streak = '0;
            end
            r.shed       = level;
            r.peak       = peak;
            r.baseline_q = baseline[FRAC +: lvg_pkg::SAMPLE_W];
            r.budget     = 16'((32'(budget_full) * 32'(level_share(level))) >> 8);
            due_outputs  = {due_outputs, r};
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [39:0] word);
            level_report_t e;
            if (due_outputs.size() == 0)
            begin
                report($sformatf("result %h with no request pending", word));
                return;
            end
            e = due_outputs.pop_front();
            if (word[2:0] !== e.shed)
                report($sformatf("shed_level %0d, want %0d", word[2:0], e.shed));
            if (word[5:3] !== e.peak)
                report($sformatf("peak_level %0d, want %0d", word[5:3], e.peak));
            if (word[21:6] !== e.baseline_q)
                report($sformatf("baseline_out %0d, want %0d", word[21:6], e.baseline_q));
            if (word[37:22] !== e.budget)
                report($sformatf("budget_out %0d, want %0d", word[37:22], e.budget));
            if (word[39:38] !== e.cls)
                report($sformatf("frame_class %0d, want %0d", word[39:38], e.cls));
        endtask
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [15:0]                 s_tdata;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [39:0]                 m_tdata;
    logic                        cfg_wen;
    logic [lvg_pkg::INDEX_W-1:0] cfg_addr;
    logic [15:0]                 cfg_wdata;

    level_tracker sb;
    bit           calm;
    int           stall_left;

    load_level_governor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        m_tready   = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 15);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);

    task send_sample(bit [15:0] s);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_sample(s);
        @(negedge clk);
    endtask

    // drop the request and wait until every result is back
    task settle();
        s_tvalid <= 1'b0;
        while (sb.due_outputs.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task put_reg(logic [lvg_pkg::INDEX_W-1:0] index, logic [15:0] value);
        cfg_wen   <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value;
        @(negedge clk);
        sb.write_reg(index, value);
    endtask

    task configure(bit [15:0] heavy, bit [15:0] quiet, bit [7:0] raise_n,
                   bit [7:0] lower_n, bit [15:0] budget);
        settle();
        put_reg(lvg_pkg::REG_HEAVY_THRESHOLD, heavy);
        put_reg(lvg_pkg::REG_QUIET_THRESHOLD, quiet);
        put_reg(lvg_pkg::REG_FRAMES_TO_RAISE, {8'($urandom), raise_n});
        put_reg(lvg_pkg::REG_FRAMES_TO_LOWER, {8'($urandom), lower_n});
        put_reg(lvg_pkg::REG_BASE_BUDGET, budget);
        cfg_wen <= 1'b0;
    endtask

    function automatic bit [15:0] heavy_sample();
        bit [31:0] lo;
        lo = 32'(sb.baseline >> FRAC) + 32'(sb.margin_now());
        if (lo < sb.heavy_thr)
            lo = sb.heavy_thr;
        lo = lo + 1;
        if (lo > 32'hFFFF)
            return 16'hFFFF;
        return 16'($urandom_range(32'hFFFF, lo));
    endfunction

    function automatic bit [15:0] quiet_sample();
        bit [31:0] hi;
        hi = (sb.baseline + (32'(sb.margin_now()) << (FRAC - 1)) - 1) >> FRAC;
        if (sb.quiet_level() > 0 && 32'(sb.quiet_level()) - 1 > hi)
            hi = 32'(sb.quiet_level()) - 1;
        if (hi > 32'hFFFF)
            hi = 32'hFFFF;
        return 16'($urandom_range(hi, 0));
    endfunction

    function automatic bit [15:0] border_sample();
        bit [15:0] pivot;
        case ($urandom_range(0, 2))
            0:       pivot = sb.heavy_thr;
            1:       pivot = sb.quiet_level();
            default: pivot = 16'(sb.baseline >> FRAC) + sb.margin_now();
        endcase
        return pivot + 16'($urandom_range(0, 4)) - 16'd2;
    endfunction

    // heavy and quiet streaks with random content, mixed with border and noise frames
    task run_phase(int n);
        int        left;
        int        len;
        int        mode;
        bit [15:0] s;
        left = n;
        while (left > 0)
        begin
            mode = $urandom_range(0, 9);
            if (mode <= 3)
                len = $urandom_range(1, sb.raise_eff() + 2);
            else if (mode <= 6)
                len = $urandom_range(1, sb.lower_eff() + 3);
            else
                len = $urandom_range(1, 3);
            if (len > left)
                len = left;
            repeat (len)
            begin
                if (mode <= 3)
                    s = heavy_sample();
                else if (mode <= 6)
                    s = quiet_sample();
                else if (mode == 7)
                    s = border_sample();
                else
                    s = 16'($urandom);
                send_sample(s);
            end
            left -= len;
        end
    endtask

    initial
    begin
        bit [15:0] opening[] = '{16'h0000, 16'hFFFF, 16'd2048, 16'd2049, 16'd1023,
                                 16'd1024, 16'h5555, 16'hAAAA, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF};
        sb        = new();
        calm      = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wen   = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening[i])
            send_sample(opening[i]);

        // zero frame counts act as one; walk the level into both limits
        configure(16'd2048, 16'd1024, 8'd0, 8'd0, 16'd1024);
        repeat (6) send_sample(16'hFFFF);
        repeat (6) send_sample(16'h0000);

        // writes to unmapped indexes change nothing
        settle();
        for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
            put_reg(lvg_pkg::INDEX_W'(i), 16'($urandom));
        cfg_wen <= 1'b0;
        run_phase(10);

        configure(lvg_pkg::HEAVY_RESET, lvg_pkg::QUIET_RESET, lvg_pkg::RAISE_RESET,
                  lvg_pkg::LOWER_RESET, lvg_pkg::BUDGET_RESET);
        run_phase(100);
        configure(16'hFFFF, 16'h0000, 8'd1, 8'd1, 16'hFFFF);
        run_phase(40);
        configure(16'h0000, 16'h0000, 8'd255, 8'd255, 16'h0000);
        run_phase(40);
        configure(16'd300, 16'hFFFF, 8'd2, 8'd5, 16'd40000);
        run_phase(80);
        repeat (3)
        begin
            configure(16'($urandom), 16'($urandom), 8'($urandom_range(1, 12)),
                      8'($urandom_range(1, 12)), 16'($urandom));
            run_phase(60);
        end

        calm = 1'b1;
        configure(16'd4096, 16'd512, 8'd4, 8'd8, 16'd777);
        run_phase(60);

        settle();
        repeat (10) @(negedge clk);
        if (sb.due_outputs.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.due_outputs.size()));
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
